@@ rtl/hsf_pkg.sv @@
// Package for the Hanning smoothing filter: sample width, request types and
// the divide-by-nine reciprocal constants. No dependencies.
`timescale 1ns / 1ps
package hsf_pkg;

    // Sample width and derived datapath widths
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_W       = SAMPLE_BITS + 4;    // signed weighted sum
    localparam int MAG_W       = SAMPLE_BITS + 3;    // magnitude of the sum
    localparam int LO_W        = MAG_W / 2;
    localparam int HI_W        = MAG_W - LO_W;

    // Divide by nine as multiply by a rounded-up reciprocal and shift
    localparam int DIVISOR     = 9;
    localparam int SHIFT_K     = MAG_W + 4;
    localparam int RCP_W       = SHIFT_K - 3;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT_K) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];
    localparam int LO_PW       = LO_W + RCP_W;
    localparam int HI_PW       = HI_W + RCP_W;
    localparam int QF_W        = MAG_W + RCP_W;

    // Sequence position bookkeeping
    localparam int         SEEN_W     = 3;
    localparam int         LINE_DEPTH = 4;
    localparam logic [2:0] FULL_COUNT = 3'd4;
    localparam logic [2:0] EDGE_COUNT = 3'd2;
    localparam logic [2:0] LAST_EDGE  = 3'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          end_of_sequence;
    } t_out_req;

endpackage

@@ rtl/hanning_smoothing_filter_core.sv @@
// Top level of the 5-tap Hanning smoothing filter (weights 1 2 3 2 1, /9).
// Depends on hsf_pkg.
`timescale 1ns / 1ps
// Takes one sample request per cycle while o_in_ready is high and returns
// one smoothed value per sample, truncated toward zero, with the two leading
// and two trailing outputs of each sequence forced to zero. A sample's
// results pass through sum, magnitude, partial products, quotient and the
// output register. Samples 3 and 4 of a sequence give no result unless final;
// the final sample gives up to three, and the output register gives them one
// at a time, so a full flush holds that register while the four pipeline
// stages take new samples behind it until they fill.
module hanning_smoothing_filter_core
    import hsf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    // Per-item result plan carried down the pipeline
    typedef struct packed {
        logic [1:0] cnt;       // results owed, 1 to 3
        logic       first_h;   // first result is the filtered value
        logic       fin;       // item closes the sequence
    } t_desc;

    // Sequence state
    logic signed [SAMPLE_BITS-1:0] r_dl [LINE_DEPTH];
    logic [SEEN_W-1:0]             r_seen;

    // Pipeline stages
    logic                          r_v1, r_v2, r_v3, r_v4;
    t_desc                         r_d1, r_d2, r_d3, r_d4;
    logic signed [ACC_W-1:0]       r_acc1;
    logic [MAG_W-1:0]              r_mag2;
    logic                          r_neg2, r_neg3, r_neg4;
    logic [LO_PW-1:0]              r_plo3;
    logic [HI_PW-1:0]              r_phi3;
    logic [SAMPLE_BITS-1:0]        r_q4;

    // Output register
    logic                          r_ov;
    t_out_req                      r_out;
    logic [1:0]                    r_rem;
    logic                          r_fin;

    logic                          accept;
    logic                          out_take;
    logic                          rdy1, rdy2, rdy3, rdy4;
    t_desc                         n_desc;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [ACC_W-1:0]       mag_full;
    logic [QF_W-1:0]               quot_full;
    logic [SAMPLE_BITS-1:0]        neg_q;

    // Ready chain: a stage moves when it is empty or the next one moves
    assign out_take   = !r_ov || (i_out_ready && (r_rem == 2'd0));
    assign rdy4       = !r_v4 || out_take;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;
    assign accept     = i_in_valid && rdy1;

    // Plan the results this sample causes
    always_comb begin
        n_desc = '0;
        if (!i_in_req.final_sample) begin
            priority if (r_seen < EDGE_COUNT) begin
                n_desc.cnt = 2'd1;
            end else if (r_seen >= FULL_COUNT) begin
                n_desc.cnt     = 2'd1;
                n_desc.first_h = 1'b1;
            end else begin
                n_desc.cnt = 2'd0;
            end
        end else begin
            n_desc.fin = 1'b1;
            priority if (r_seen <= EDGE_COUNT) begin
                n_desc.cnt = 2'd1;
            end else if (r_seen == LAST_EDGE) begin
                n_desc.cnt = 2'd2;
            end else begin
                n_desc.cnt     = 2'd3;
                n_desc.first_h = 1'b1;
            end
        end
    end

    // Weighted sum over the delay line and the new sample
    assign n_acc = ACC_W'(r_dl[0]) + (ACC_W'(r_dl[1]) <<< 1) + ACC_W'(r_dl[2])
                 + (ACC_W'(r_dl[2]) <<< 1) + (ACC_W'(r_dl[3]) <<< 1)
                 + ACC_W'(i_in_req.sample);

    // Advance the delay line; clear it at the end of a sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINE_DEPTH; k++) begin
                r_dl[k] <= '0;
            end
            r_seen <= '0;
        end else if (accept) begin
            if (i_in_req.final_sample) begin
                for (int k = 0; k < LINE_DEPTH; k++) begin
                    r_dl[k] <= '0;
                end
                r_seen <= '0;
            end else begin
                for (int k = 0; k < LINE_DEPTH - 1; k++) begin
                    r_dl[k] <= r_dl[k+1];
                end
                r_dl[LINE_DEPTH-1] <= i_in_req.sample;
                if (r_seen < FULL_COUNT) begin
                    r_seen <= r_seen + 3'd1;
                end
            end
        end
    end

    // Stage valids; samples with no result are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept && (n_desc.cnt != 2'd0);
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign mag_full  = r_acc1[ACC_W-1] ? -r_acc1 : r_acc1;
    assign quot_full = (QF_W'(r_phi3) << LO_W) + QF_W'(r_plo3);

    // Stage payloads: sum, magnitude, partial products, quotient
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_d1   <= n_desc;
            r_acc1 <= n_acc;
        end
        if (rdy2) begin
            r_d2   <= r_d1;
            r_neg2 <= r_acc1[ACC_W-1];
            r_mag2 <= mag_full[MAG_W-1:0];
        end
        if (rdy3) begin
            r_d3   <= r_d2;
            r_neg3 <= r_neg2;
            r_plo3 <= LO_PW'(r_mag2[LO_W-1:0]) * LO_PW'(RCP);
            r_phi3 <= HI_PW'(r_mag2[MAG_W-1:LO_W]) * HI_PW'(RCP);
        end
        if (rdy4) begin
            r_d4   <= r_d3;
            r_neg4 <= r_neg3;
            r_q4   <= quot_full[SHIFT_K +: SAMPLE_BITS];
        end
    end

    assign neg_q = r_neg4 ? -r_q4 : r_q4;

    // Output register: load a new item or step through the owed zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_take) begin
            r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out.smoothed        <= r_d4.first_h ? neg_q : '0;
            r_out.end_of_sequence <= r_d4.fin && (r_d4.cnt == 2'd1);
            r_rem                 <= r_d4.cnt - 2'd1;
            r_fin                 <= r_d4.fin;
        end else if (r_ov && i_out_ready) begin
            r_out.smoothed        <= '0;
            r_out.end_of_sequence <= r_fin && (r_rem == 2'd1);
            r_rem                 <= r_rem - 2'd1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_req   = r_out;

endmodule

@@ rtl/hsf_checker.sv @@
// Port-level checker for the Hanning smoothing filter, bound to the top level.
// Depends on hsf_pkg and hanning_smoothing_filter_core.
`timescale 1ns / 1ps
module hsf_checker
    import hsf_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_in_req  i_in_req,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_req
);

    logic       fin_in;
    logic       eos_out;
    logic [3:0] r_open;

    assign fin_in  = i_in_valid && o_in_ready && i_in_req.final_sample;
    assign eos_out = o_out_valid && i_out_ready && o_out_req.end_of_sequence;

    // Track sequences closed at the input but not yet at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 4'(fin_in) - 4'(eos_out);
        end
    end

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("output request changed while stalled");

    // Drop all results at reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // Close a sequence only after its final sample went in
    a_eos_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eos_out |-> r_open != 4'd0)
        else $error("end of sequence without a final sample");

    // Keep taking samples while the output side is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output");

endmodule

bind hanning_smoothing_filter_core hsf_checker u_hsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

@@ tb/tb_top.sv @@
// Testbench for hanning_smoothing_filter_core: a directed table of sample requests,
// then random sequences, checked against typed results or a behavioral predictor.
// Depends on hsf_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb_top;
    import hsf_pkg::*;

    localparam int RANDOM_ITEMS = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PREDICT      = 0;    // row result source: predictor
    localparam int TYPED        = 1;    // row result source: typed in the table

    localparam t_out_req Z_MID = '{smoothed: 16'sd0, end_of_sequence: 1'b0};
    localparam t_out_req Z_END = '{smoothed: 16'sd0, end_of_sequence: 1'b1};
    localparam t_out_req Y_MAX = '{smoothed: 16'sh7fff, end_of_sequence: 1'b0};
    localparam t_out_req Y_MIN = '{smoothed: 16'sh8000, end_of_sequence: 1'b0};

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RARE_STALL} t_rx_style;

    // One table row: the request and, when typed, its expected results
    typedef struct packed {
        t_in_req  req;
        logic     typed;
        logic [1:0] n_typed;
        t_out_req r0;
        t_out_req r1;
        t_out_req r2;
    } t_stim_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_in_req  i_in_req    = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_out_req o_out_req;

    hanning_smoothing_filter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    // Predictor state: four most recent samples, oldest first, and position
    logic signed [SAMPLE_BITS-1:0] taps [LINE_DEPTH];
    logic [SEEN_W-1:0]             seq_pos = '0;

    t_out_req  smoothed_due [$];
    t_out_req  fresh [$];
    t_stim_row table_rows [$];
    t_out_req  due_head;

    int        errors        = 0;
    int        cycle_count   = 0;
    int        samples_taken = 0;
    int        results_seen  = 0;
    int        sequences     = 0;
    int        burst_left    = 0;
    int        rx_hold       = 0;
    t_rx_style rx_style      = RX_OPEN;

    // Clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Count cycles and stop the run at the limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 smoothed_due.size());
        $display("tb_top failed");
        $finish;
    end

    // Receiver: switch between stall styles at random intervals
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 3));
            rx_hold  <= $urandom_range(16, 80);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_style)
            RX_OPEN:       i_out_ready <= 1'b1;
            RX_COIN:       i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:     i_out_ready <= (cycle_count % 4 == 0);
            RX_RARE_STALL: i_out_ready <= ($urandom_range(0, 9) != 0);
            default:       i_out_ready <= 1'b1;
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (smoothed_due.size() == 0) begin
                report_mismatch("unexpected result, smoothed", o_out_req.smoothed, 0);
            end else begin
                due_head = smoothed_due.pop_front();
                if (o_out_req.smoothed !== due_head.smoothed)
                    report_mismatch("smoothed", o_out_req.smoothed, due_head.smoothed);
                if (o_out_req.end_of_sequence !== due_head.end_of_sequence)
                    report_mismatch("end_of_sequence", o_out_req.end_of_sequence,
                                    due_head.end_of_sequence);
            end
        end
    end

    // Advance the predictor by one sample; the results it owes land in fresh
    task automatic smooth_sample(input t_in_req r);
        int       acc;
        t_out_req y;
        fresh.delete();
        acc = taps[0] + 2 * taps[1] + 3 * taps[2] + 2 * taps[3] + r.sample;
        y.smoothed        = 16'(acc / DIVISOR);
        y.end_of_sequence = 1'b0;
        if (!r.final_sample) begin
            if (seq_pos < EDGE_COUNT)
                fresh.push_back(Z_MID);
            else if (seq_pos >= FULL_COUNT)
                fresh.push_back(y);
            for (int i = 0; i < LINE_DEPTH - 1; i++)
                taps[i] = taps[i + 1];
            taps[LINE_DEPTH - 1] = r.sample;
            if (seq_pos < FULL_COUNT)
                seq_pos = seq_pos + 1'b1;
        end else begin
            if (seq_pos <= EDGE_COUNT) begin
                fresh.push_back(Z_END);
            end else if (seq_pos == LAST_EDGE) begin
                fresh.push_back(Z_MID);
                fresh.push_back(Z_END);
            end else begin
                fresh.push_back(y);
                fresh.push_back(Z_MID);
                fresh.push_back(Z_END);
            end
            for (int i = 0; i < LINE_DEPTH; i++)
                taps[i] = '0;
            seq_pos = '0;
        end
    endtask

    task automatic add_row(input logic signed [SAMPLE_BITS-1:0] s, input logic fin,
                           input int source, input int n, input t_out_req a,
                           input t_out_req b, input t_out_req c);
        t_stim_row row;
        row.req.sample       = s;
        row.req.final_sample = fin;
        row.typed            = (source == TYPED);
        row.n_typed          = 2'(n);
        row.r0               = a;
        row.r1               = b;
        row.r2               = c;
        table_rows.push_back(row);
    endtask

    // Drive one request in bursts with random gaps; record what it owes
    task automatic send_row(input t_stim_row row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_req   <= row.req;
        do @(posedge i_clk); while (!o_in_ready);
        smooth_sample(row.req);
        if (row.typed) begin
            if (row.n_typed > 0) smoothed_due.push_back(row.r0);
            if (row.n_typed > 1) smoothed_due.push_back(row.r1);
            if (row.n_typed > 2) smoothed_due.push_back(row.r2);
        end else begin
            foreach (fresh[i]) smoothed_due.push_back(fresh[i]);
        end
        samples_taken++;
        if (row.req.final_sample) sequences++;
    endtask

    // Hold the sender until every owed result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (smoothed_due.size() != 0);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 40) - 20);
            3:       return 16'($urandom_range(0, 1) ? 16'sh7ff0 + $urandom_range(0, 15)
                                                     : 16'sh8000 + $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_stim_row row;
        int        len;
        int        random_sent;
        logic      paused_once;
        random_sent = 0;
        paused_once = 1'b0;
        for (int i = 0; i < LINE_DEPTH; i++)
            taps[i] = '0;

        // Short sequences: one, two, three and four samples
        add_row(16'sh7fff, 1'b1, TYPED, 1, Z_END, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b1, TYPED, 1, Z_END, Z_MID, Z_MID);
        add_row(16'sd1,    1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sd2,    1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sd3,    1'b1, TYPED, 1, Z_END, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b1, TYPED, 2, Z_MID, Z_END, Z_MID);
        // Full flush at the positive extreme
        add_row(16'sh7fff, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b0, TYPED, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b0, TYPED, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sh7fff, 1'b1, TYPED, 3, Y_MAX, Z_MID, Z_END);
        // Negative extreme, one steady-state output before the flush
        add_row(16'sh8000, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 1, Z_MID, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b0, TYPED, 1, Y_MIN, Z_MID, Z_MID);
        add_row(16'sh8000, 1'b1, TYPED, 3, Y_MIN, Z_MID, Z_END);
        // Negative sum that must truncate toward zero
        add_row(-16'sd10,  1'b0, PREDICT, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sd0,    1'b0, PREDICT, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sd0,    1'b0, PREDICT, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sd0,    1'b0, PREDICT, 0, Z_MID, Z_MID, Z_MID);
        add_row(16'sd0,    1'b1, PREDICT, 0, Z_MID, Z_MID, Z_MID);

        // Reset, then walk the table
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[i]) send_row(table_rows[i]);
        wait_for_results();

        // Random sequences, mostly long enough to reach the steady state
        while (random_sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
            for (int k = 0; k < len; k++) begin
                row                  = '0;
                row.req.sample       = pick_sample();
                row.req.final_sample = (k == len - 1);
                row.typed            = 1'b0;
                send_row(row);
                random_sent++;
            end
            if (!paused_once && random_sent >= RANDOM_ITEMS / 2) begin
                wait_for_results();
                paused_once = 1'b1;
            end
        end

        // Drain, then give the pipeline time to show any stray result
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples in %0d sequences, %0d results checked",
                 samples_taken, sequences, results_seen);
        $display("short sequences, full flushes at both extremes, random bursts and stalls");
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
